// ----- src/sist_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sist_pkg;

    // Fixed field widths
    localparam int POS_W = 32;
    localparam int EXT_W = 24;
    localparam int ID_W  = 6;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_RESP
    } t_state;

    // One table entry
    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch input beat, load walk index
        logic rd_en;       // read entry at walk index - 1
        logic shift_wr;    // move read entry up to walk index
        logic dec;         // walk index - 1
        logic ins_wr;      // write new entry at walk index
        logic set_full;    // result: insert rejected
        logic do_clear;    // empty the table
        logic load_match;  // result: matched id from read entry
        logic push;        // load output register from result
        logic push_last;   // last flag for the pushed beat
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       walk_zero;
        logic       start_gt;
        logic       match;
        logic       res_found;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/sist_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sist_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  sist_pkg::t_sts     i_sts,
    output sist_pkg::t_cmd     o_cmd
);

    sist_pkg::t_state r_state;
    sist_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sist_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sist_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sist_pkg::ST_DECODE;
                end
            end
            sist_pkg::ST_DECODE: begin
                case (i_sts.op)
                    sist_pkg::OP_INSERT: begin
                        n_state = i_sts.full ? sist_pkg::ST_RESP : sist_pkg::ST_INS_RD;
                    end
                    sist_pkg::OP_QUERY: n_state = sist_pkg::ST_QRY_RD;
                    default:            n_state = sist_pkg::ST_RESP;
                endcase
            end
            sist_pkg::ST_INS_RD: begin
                n_state = i_sts.walk_zero ? sist_pkg::ST_RESP : sist_pkg::ST_INS_CMP;
            end
            sist_pkg::ST_INS_CMP: begin
                n_state = i_sts.start_gt ? sist_pkg::ST_INS_RD : sist_pkg::ST_RESP;
            end
            sist_pkg::ST_QRY_RD: begin
                n_state = i_sts.walk_zero ? sist_pkg::ST_RESP : sist_pkg::ST_QRY_CMP;
            end
            sist_pkg::ST_QRY_CMP: begin
                // a second match must first flush the held one
                if (!(i_sts.match && i_sts.res_found && !i_sts.out_free)) begin
                    n_state = sist_pkg::ST_QRY_RD;
                end
            end
            sist_pkg::ST_RESP: begin
                if (i_sts.out_free) begin
                    n_state = sist_pkg::ST_IDLE;
                end
            end
            default: n_state = sist_pkg::ST_IDLE;
        endcase
    end

    // Outputs; input held off while in reset
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != sist_pkg::ST_IDLE) || !i_rst_n;
        case (r_state)
            sist_pkg::ST_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            sist_pkg::ST_DECODE: begin
                o_cmd.set_full = (i_sts.op == sist_pkg::OP_INSERT) && i_sts.full;
                o_cmd.do_clear = (i_sts.op == sist_pkg::OP_CLEAR);
            end
            sist_pkg::ST_INS_RD: begin
                o_cmd.ins_wr = i_sts.walk_zero;
                o_cmd.rd_en  = !i_sts.walk_zero;
            end
            sist_pkg::ST_INS_CMP: begin
                o_cmd.shift_wr = i_sts.start_gt;
                o_cmd.dec      = i_sts.start_gt;
                o_cmd.ins_wr   = !i_sts.start_gt;
            end
            sist_pkg::ST_QRY_RD: begin
                o_cmd.rd_en = !i_sts.walk_zero;
            end
            sist_pkg::ST_QRY_CMP: begin
                if (i_sts.match && i_sts.res_found) begin
                    if (i_sts.out_free) begin
                        o_cmd.push       = 1'b1;
                        o_cmd.load_match = 1'b1;
                        o_cmd.dec        = 1'b1;
                    end
                end else begin
                    o_cmd.load_match = i_sts.match;
                    o_cmd.dec        = 1'b1;
                end
            end
            sist_pkg::ST_RESP: begin
                o_cmd.push      = i_sts.out_free;
                o_cmd.push_last = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/sist_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sist_dpath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  sist_pkg::t_cmd                 i_cmd,
    output sist_pkg::t_sts                 o_sts,
    input  wire logic                      i_cfg_we,
    input  wire logic [sist_pkg::EXT_W-1:0] i_cfg_wdata,
    input  wire logic [1:0]                i_operation,
    input  wire logic [sist_pkg::POS_W-1:0] i_position,
    input  wire logic [sist_pkg::POS_W-1:0] i_interval_end,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic [sist_pkg::ID_W-1:0]      o_entry_id,
    output logic                           o_found,
    output logic                           o_last,
    output logic                           o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Table storage, one write and one registered read per cycle
    sist_pkg::t_entry r_mem [TABLE_DEPTH];
    sist_pkg::t_entry r_rd;

    logic [sist_pkg::EXT_W-1:0] r_ext;
    logic [CW-1:0]              r_count;
    logic [sist_pkg::ID_W-1:0]  r_next_id;
    logic [CW-1:0]              r_walk;
    logic [1:0]                 r_op;
    logic [sist_pkg::POS_W-1:0] r_pos;
    logic [sist_pkg::POS_W-1:0] r_ins_start;
    logic [sist_pkg::POS_W-1:0] r_ins_end;
    logic [sist_pkg::ID_W-1:0]  r_res_id;
    logic                       r_res_found;
    logic                       r_res_status;
    logic                       r_out_valid;
    logic [sist_pkg::ID_W-1:0]  r_out_id;
    logic                       r_out_found;
    logic                       r_out_last;
    logic                       r_out_status;

    logic [sist_pkg::POS_W-1:0] w_ext32;
    logic [sist_pkg::POS_W-1:0] w_start;
    logic [sist_pkg::POS_W:0]   w_end_sum;
    logic [sist_pkg::POS_W-1:0] w_end;
    logic [CW-1:0]              w_walk_m1;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_wr_addr;
    logic                       w_wr_en;
    sist_pkg::t_entry           w_wr_data;
    logic                       w_out_free;

    // Interval widening at accept
    assign w_ext32   = {{(sist_pkg::POS_W - sist_pkg::EXT_W){1'b0}}, r_ext};
    assign w_start   = (i_position > w_ext32) ? (i_position - w_ext32)
                                              : sist_pkg::POS_W'(1);
    assign w_end_sum = {1'b0, i_interval_end} + {1'b0, w_ext32};
    assign w_end     = w_end_sum[sist_pkg::POS_W] ? '1 : w_end_sum[sist_pkg::POS_W-1:0];

    // Walk addressing: read below the index, write at it
    assign w_walk_m1 = r_walk - CW'(1);
    assign w_rd_addr = w_walk_m1[AW-1:0];
    assign w_wr_addr = r_walk[AW-1:0];
    assign w_wr_en   = i_cmd.shift_wr || i_cmd.ins_wr;

    always_comb begin
        if (i_cmd.ins_wr) begin
            w_wr_data.start_pos = r_ins_start;
            w_wr_data.end_pos   = r_ins_end;
            w_wr_data.id        = r_next_id;
        end else begin
            w_wr_data = r_rd;
        end
    end

    // Memory write
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // Memory read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext <= '0;
        end else if (i_cfg_we) begin
            r_ext <= i_cfg_wdata;
        end
    end

    // Table occupancy and id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= '0;
        end else if (i_cmd.do_clear) begin
            r_count <= '0;
        end else if (i_cmd.ins_wr) begin
            r_count   <= r_count + CW'(1);
            r_next_id <= r_next_id + sist_pkg::ID_W'(1);
        end
    end

    // Input beat capture and walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_operation;
            r_pos       <= i_position;
            r_ins_start <= w_start;
            r_ins_end   <= w_end;
            r_walk      <= r_count;
        end else if (i_cmd.dec) begin
            r_walk <= w_walk_m1;
        end
    end

    // Result being built for the current item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_found  <= 1'b0;
            r_res_status <= 1'b0;
            r_res_id     <= '0;
        end else if (i_cmd.accept) begin
            r_res_found  <= 1'b0;
            r_res_status <= 1'b0;
            r_res_id     <= '0;
        end else if (i_cmd.set_full) begin
            r_res_status <= 1'b1;
        end else if (i_cmd.ins_wr) begin
            r_res_found <= 1'b1;
            r_res_id    <= r_next_id;
        end else if (i_cmd.load_match) begin
            r_res_found <= 1'b1;
            r_res_id    <= r_rd.id;
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_id     <= r_res_id;
            r_out_found  <= r_res_found;
            r_out_last   <= i_cmd.push_last;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_entry_id  = r_out_id;
    assign o_found     = r_out_found;
    assign o_last      = r_out_last;
    assign o_status    = r_out_status;

    // Status to controller
    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.walk_zero = (r_walk == '0);
    assign o_sts.start_gt  = (r_rd.start_pos > r_ins_start);
    assign o_sts.match     = (r_rd.start_pos <= r_pos) && (r_pos <= r_rd.end_pos);
    assign o_sts.res_found = r_res_found;
    assign o_sts.out_free  = w_out_free;

endmodule

`default_nettype wire

// ----- src/sorted_interval_stabbing_table.sv -----
// Sorted interval table with stabbing queries. Intervals are kept sorted by
// widened start in a single-port-read, single-port-write memory, and every item
// is worked one at a time: an insert reads each stored entry whose start is
// above the new one and moves it up a slot, then writes the new entry below
// them; a query walks from the top entry down, reading and comparing each
// stored entry and giving one beat per match; clear, a rejected insert and the
// unused code go straight to the response beat. The one memory read port, with
// its registered data, means each entry is read in a read state and compared
// in a compare state. A result beat waiting in the output register does not
// stop the next item from being taken; later beats wait only when that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module sorted_interval_stabbing_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [sist_pkg::EXT_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [sist_pkg::POS_W-1:0] i_position,
    input  wire logic [sist_pkg::POS_W-1:0] i_interval_end,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [sist_pkg::ID_W-1:0]       o_entry_id,
    output logic                            o_found,
    output logic                            o_last,
    output logic                            o_status
);

    sist_pkg::t_cmd w_cmd;
    sist_pkg::t_sts w_sts;

    sist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sist_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_interval_end (i_interval_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_entry_id     (o_entry_id),
        .o_found        (o_found),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ----- src/sist_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sist_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       o_in_stall,
    input  wire logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [sist_pkg::ID_W-1:0]  o_entry_id,
    input  wire logic                       o_found,
    input  wire logic                       o_last,
    input  wire logic                       o_status
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_entry_id) && $stable(o_found)
            && $stable(o_last) && $stable(o_status))
        else $error("result beat changed while stalled");

    // One item at a time: input stalls right after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

    // A rejected insert is a lone, not-found beat
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_last && !o_found && (o_entry_id == '0))
        else $error("bad rejected-insert beat");

    // A not-found beat always ends its item and carries id zero
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && (o_entry_id == '0))
        else $error("not-found beat is not final");

endmodule

bind sorted_interval_stabbing_table sist_checker u_sist_checker (.*);

`default_nettype wire
